@@ sv/hop_channel_quality_denylist_assert.svh @@
// Assertion macros used by the bound checker (hcqd_checker.sv).
`ifndef HOP_CHANNEL_QUALITY_DENYLIST_ASSERT_SVH
`define HOP_CHANNEL_QUALITY_DENYLIST_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define HCQD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcqd assertion failed");

// Next-cycle implication, disabled in reset.
`define HCQD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcqd assertion failed");

`endif

@@ sv/hcqd_pkg.sv @@
package hcqd_pkg;

   localparam int unsigned COUNT_W = 7;  // effective channel count, at most 63 (clamped to CHANNELS_MAX)
   localparam int unsigned SYNC_W  = 6;

   localparam logic [7:0] CNT_SAT   = 8'd255;
   localparam logic [7:0] RATE_NONE = 8'd255;
   localparam logic [14:0] PCT      = 15'd100;
   localparam logic [2:0] QUO_TOP   = 3'd6;    // quotient <= 100 fits 7 bits
   localparam logic [COUNT_W-1:0] MIN_BUILD = 7'd8;

   typedef enum logic [2:0] {
      REG_SMART = 3'd0,
      REG_COUNT = 3'd1,
      REG_SYNC  = 3'd2,
      REG_MIN   = 3'd3,
      REG_SCORE = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV,
      ST_SCAN_RD,
      ST_SCAN_LD,
      ST_INSERT,
      ST_MARK,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic [5:0]        channel;
      logic              received_ok;
      logic signed [7:0] signal_strength;
      logic              in_range;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic               smart_enable;
      logic [COUNT_W-1:0] count;
      logic [SYNC_W-1:0]  sync;
      logic [8:0]         min_samples;
      logic [6:0]         deny_score;
      logic               clear;
   } cfg_type;

   typedef struct packed {
      logic [7:0]        hit;
      logic [7:0]        miss;
      logic signed [7:0] rssi;
   } stat_type;

endpackage

@@ sv/hcqd_front.sv @@
module hcqd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [5:0]               req_channel,
   input  logic                     req_received_ok,
   input  logic signed [7:0]        req_signal_strength,
   input  hcqd_pkg::cfg_type        cfg,
   output hcqd_pkg::queue_head_type head,
   input  logic                     pop
);

   hcqd_pkg::item_type slot_ff [2];
   logic [1:0]         cnt_ff, cnt_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic               push;
   logic               wr_ptr;
   hcqd_pkg::item_type new_item;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign wr_ptr    = rd_ptr_ff ^ cnt_ff[0];

   // classify on entry: out-of-range records bypass the statistics
   always_comb begin
      new_item.channel         = req_channel;
      new_item.received_ok     = req_received_ok;
      new_item.signal_strength = req_signal_strength;
      new_item.in_range        = ({1'b0, req_channel} < cfg.count);
   end

   always_comb begin
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_ptr_in = rd_ptr_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr] <= new_item;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

endmodule

@@ sv/hcqd_back.sv @@
module hcqd_back #(
   parameter int CHANNELS_MAX = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hcqd_pkg::cfg_type        cfg,
   input  hcqd_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_accepted,
   output logic [7:0]               rsp_hit_count,
   output logic [7:0]               rsp_miss_count,
   output logic [7:0]               rsp_miss_percent,
   output logic signed [7:0]        rsp_rssi_average,
   output logic                     rsp_channel_denied,
   output logic [4:0]               rsp_denied_total,
   output logic [31:0]              rsp_denied_mask
);

   localparam int CHW   = $clog2(CHANNELS_MAX);
   localparam int KMAX  = CHANNELS_MAX / 4;
   localparam int KIW   = (KMAX > 1) ? $clog2(KMAX) : 1;
   localparam int MASKW = (CHANNELS_MAX < 32) ? CHANNELS_MAX : 32;
   localparam int CW    = hcqd_pkg::COUNT_W;

   hcqd_pkg::seq_state_type state_ff, state_in;

   hcqd_pkg::stat_type mem [CHANNELS_MAX];
   hcqd_pkg::stat_type rd_data_ff;
   logic               rd_vld_ff;
   logic [CHW-1:0]     mem_rd_idx;
   logic               mem_we;

   logic [CHANNELS_MAX-1:0] stat_vld_ff;
   logic [CHANNELS_MAX-1:0] seen_ff;
   logic [CHANNELS_MAX-1:0] flags_ff;
   logic [4:0]              total_ff;

   hcqd_pkg::item_type item_ff;
   logic [7:0]         hit_ff, miss_ff, rate_ff;
   logic signed [7:0]  rssi_ff;
   logic [CW-1:0]      scan_ff, mark_ff;

   logic [14:0] div_rem_ff;
   logic [8:0]  div_den_ff;
   logic [6:0]  div_q_ff;
   logic [2:0]  div_step_ff;
   logic        div_scan_ff;
   logic [6:0]  cand_ff;

   logic       list_vld_ff  [KMAX];
   logic [6:0] list_rate_ff [KMAX];
   logic [CHW-1:0] list_idx_ff [KMAX];
   logic       list_vld_in  [KMAX];
   logic [6:0] list_rate_in [KMAX];
   logic [CHW-1:0] list_idx_in [KMAX];
   logic [KMAX-1:0] gt;

   logic        rsp_valid_ff;
   logic        acc_ff, den_ff;
   logic [7:0]  o_hit_ff, o_miss_ff, o_rate_ff;
   logic signed [7:0] o_rssi_ff;
   logic [4:0]  o_total_ff;
   logic [31:0] o_mask_ff;

   hcqd_pkg::stat_type rd_stat;
   logic [CHW-1:0]     ich;
   logic               halve;
   logic [7:0]         h0, m0, upd_hit, upd_miss;
   logic signed [11:0] rssi_sum, rssi_adj, rssi_div;
   logic signed [7:0]  upd_rssi;
   logic [8:0]         upd_samples, scn_samples;
   logic               upd_short, scn_skip;
   logic [15:0]        div_sh;
   logic               div_ge;
   logic [14:0]        div_rem_nx;
   logic [6:0]         div_q_nx;
   logic               build, last, mark_go, eligible;
   logic [CW-1:0]      cap;
   logic [31:0]        mask_now;

   // ---------------- datapath helpers ----------------
   assign rd_stat = rd_vld_ff ? rd_data_ff : '0;
   assign ich     = item_ff.channel[CHW-1:0];

   always_comb begin
      halve    = (rd_stat.hit == hcqd_pkg::CNT_SAT) || (rd_stat.miss == hcqd_pkg::CNT_SAT);
      h0       = halve ? (rd_stat.hit >> 1) : rd_stat.hit;
      m0       = halve ? (rd_stat.miss >> 1) : rd_stat.miss;
      upd_hit  = item_ff.received_ok ? h0 + 8'd1 : h0;
      upd_miss = item_ff.received_ok ? m0 : m0 + 8'd1;
      // 7/8 EWMA, rounded toward zero
      rssi_sum = (12'(rd_stat.rssi) <<< 3) - 12'(rd_stat.rssi) + 12'(item_ff.signal_strength);
      rssi_adj = rssi_sum + (rssi_sum[11] ? 12'sd7 : 12'sd0);
      rssi_div = rssi_adj >>> 3;
      if (!item_ff.received_ok) begin
         upd_rssi = rd_stat.rssi;
      end else if (!seen_ff[ich]) begin
         upd_rssi = item_ff.signal_strength;
      end else begin
         upd_rssi = rssi_div[7:0];
      end
      upd_samples = {1'b0, upd_hit} + {1'b0, upd_miss};
      upd_short   = (upd_samples < cfg.min_samples) || (upd_samples == 9'd0);
      scn_samples = {1'b0, rd_stat.hit} + {1'b0, rd_stat.miss};
      scn_skip    = (scan_ff == {1'b0, cfg.sync}) || (scn_samples < cfg.min_samples) ||
                    (scn_samples == 9'd0);
   end

   // one quotient bit per cycle
   always_comb begin
      div_sh     = {7'd0, div_den_ff} << div_step_ff;
      div_ge     = ({1'b0, div_rem_ff} >= div_sh);
      div_rem_nx = div_ge ? (div_rem_ff - div_sh[14:0]) : div_rem_ff;
      div_q_nx   = div_q_ff | (div_ge ? (7'd1 << div_step_ff) : 7'd0);
   end

   assign build    = cfg.smart_enable && (cfg.count >= hcqd_pkg::MIN_BUILD);
   assign cap      = cfg.count >> 2;
   assign last     = ((scan_ff + 1'b1) == cfg.count);
   assign mark_go  = (mark_ff < cap) && list_vld_ff[mark_ff[KIW-1:0]];
   assign eligible = (cand_ff >= cfg.deny_score) && (cand_ff != 7'd0);

   // sorted insert: rate descending, earlier index wins ties
   always_comb begin
      for (int k = 0; k < KMAX; k++) begin
         gt[k] = !list_vld_ff[k] || (cand_ff > list_rate_ff[k]);
      end
      for (int k = 0; k < KMAX; k++) begin
         list_vld_in[k]  = list_vld_ff[k];
         list_rate_in[k] = list_rate_ff[k];
         list_idx_in[k]  = list_idx_ff[k];
         if (gt[k]) begin
            if (k == 0 || !gt[(k > 0) ? k - 1 : 0]) begin
               list_vld_in[k]  = 1'b1;
               list_rate_in[k] = cand_ff;
               list_idx_in[k]  = scan_ff[CHW-1:0];
            end else begin
               list_vld_in[k]  = list_vld_ff[(k > 0) ? k - 1 : 0];
               list_rate_in[k] = list_rate_ff[(k > 0) ? k - 1 : 0];
               list_idx_in[k]  = list_idx_ff[(k > 0) ? k - 1 : 0];
            end
         end
      end
   end

   always_comb begin
      mask_now = '0;
      for (int b = 0; b < MASKW; b++) begin
         mask_now[b] = flags_ff[b];
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hcqd_pkg::ST_IDLE: begin
            if (head.valid && !rsp_valid_ff && head.item.in_range) begin
               state_in = hcqd_pkg::ST_UPDATE;
            end
         end
         hcqd_pkg::ST_UPDATE: begin
            if (!upd_short) begin
               state_in = hcqd_pkg::ST_DIV;
            end else begin
               state_in = build ? hcqd_pkg::ST_SCAN_RD : hcqd_pkg::ST_DONE;
            end
         end
         hcqd_pkg::ST_DIV: begin
            if (div_step_ff == 3'd0) begin
               if (div_scan_ff) begin
                  state_in = hcqd_pkg::ST_INSERT;
               end else begin
                  state_in = build ? hcqd_pkg::ST_SCAN_RD : hcqd_pkg::ST_DONE;
               end
            end
         end
         hcqd_pkg::ST_SCAN_RD: begin
            state_in = hcqd_pkg::ST_SCAN_LD;
         end
         hcqd_pkg::ST_SCAN_LD: begin
            if (!scn_skip) begin
               state_in = hcqd_pkg::ST_DIV;
            end else begin
               state_in = last ? hcqd_pkg::ST_MARK : hcqd_pkg::ST_SCAN_RD;
            end
         end
         hcqd_pkg::ST_INSERT: begin
            state_in = last ? hcqd_pkg::ST_MARK : hcqd_pkg::ST_SCAN_RD;
         end
         hcqd_pkg::ST_MARK: begin
            if (!mark_go) begin
               state_in = hcqd_pkg::ST_DONE;
            end
         end
         hcqd_pkg::ST_DONE: begin
            state_in = hcqd_pkg::ST_IDLE;
         end
         default: begin
            state_in = hcqd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pop        = 1'b0;
      mem_we     = 1'b0;
      mem_rd_idx = scan_ff[CHW-1:0];
      case (state_ff)
         hcqd_pkg::ST_IDLE: begin
            pop        = head.valid && !rsp_valid_ff;
            mem_rd_idx = head.item.channel[CHW-1:0];
         end
         hcqd_pkg::ST_UPDATE: begin
            mem_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcqd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // statistics memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ich] <= '{hit: upd_hit, miss: upd_miss, rssi: upd_rssi};
      end
      rd_data_ff <= mem[mem_rd_idx];
      rd_vld_ff  <= stat_vld_ff[mem_rd_idx];
   end

   // control state: entry valid bits, flags, list, response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         stat_vld_ff  <= '0;
         seen_ff      <= '0;
         flags_ff     <= '0;
         total_ff     <= 5'd0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < KMAX; k++) begin
            list_vld_ff[k] <= 1'b0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            hcqd_pkg::ST_IDLE: begin
               if (pop && !head.item.in_range) begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            hcqd_pkg::ST_UPDATE: begin
               stat_vld_ff[ich] <= 1'b1;
               if (item_ff.received_ok) begin
                  seen_ff[ich] <= 1'b1;
               end
               flags_ff <= '0;
               total_ff <= 5'd0;
               for (int k = 0; k < KMAX; k++) begin
                  list_vld_ff[k] <= 1'b0;
               end
            end
            hcqd_pkg::ST_INSERT: begin
               if (eligible) begin
                  for (int k = 0; k < KMAX; k++) begin
                     list_vld_ff[k] <= list_vld_in[k];
                  end
               end
            end
            hcqd_pkg::ST_MARK: begin
               if (mark_go) begin
                  flags_ff[list_idx_ff[mark_ff[KIW-1:0]]] <= 1'b1;
                  total_ff <= total_ff + 5'd1;
               end
            end
            hcqd_pkg::ST_DONE: begin
               rsp_valid_ff <= 1'b1;
            end
            default: begin
            end
         endcase
         if (cfg.clear) begin
            stat_vld_ff <= '0;
            seen_ff     <= '0;
            flags_ff    <= '0;
            total_ff    <= 5'd0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (state_ff)
         hcqd_pkg::ST_IDLE: begin
            if (pop) begin
               item_ff    <= head.item;
               acc_ff     <= 1'b0;
               o_hit_ff   <= 8'd0;
               o_miss_ff  <= 8'd0;
               o_rate_ff  <= hcqd_pkg::RATE_NONE;
               o_rssi_ff  <= 8'sd0;
               den_ff     <= 1'b0;
               o_total_ff <= total_ff;
               o_mask_ff  <= mask_now;
            end
         end
         hcqd_pkg::ST_UPDATE: begin
            hit_ff      <= upd_hit;
            miss_ff     <= upd_miss;
            rssi_ff     <= upd_rssi;
            rate_ff     <= hcqd_pkg::RATE_NONE;
            div_rem_ff  <= 15'(upd_miss) * hcqd_pkg::PCT;
            div_den_ff  <= upd_samples;
            div_q_ff    <= 7'd0;
            div_step_ff <= hcqd_pkg::QUO_TOP;
            div_scan_ff <= 1'b0;
            scan_ff     <= '0;
            mark_ff     <= '0;
         end
         hcqd_pkg::ST_DIV: begin
            div_rem_ff  <= div_rem_nx;
            div_q_ff    <= div_q_nx;
            div_step_ff <= div_step_ff - 3'd1;
            if (div_step_ff == 3'd0) begin
               if (div_scan_ff) begin
                  cand_ff <= div_q_nx;
               end else begin
                  rate_ff <= {1'b0, div_q_nx};
               end
            end
         end
         hcqd_pkg::ST_SCAN_LD: begin
            if (scn_skip) begin
               scan_ff <= scan_ff + 1'b1;
            end else begin
               div_rem_ff  <= 15'(rd_stat.miss) * hcqd_pkg::PCT;
               div_den_ff  <= scn_samples;
               div_q_ff    <= 7'd0;
               div_step_ff <= hcqd_pkg::QUO_TOP;
               div_scan_ff <= 1'b1;
            end
         end
         hcqd_pkg::ST_INSERT: begin
            scan_ff <= scan_ff + 1'b1;
            if (eligible) begin
               for (int k = 0; k < KMAX; k++) begin
                  list_rate_ff[k] <= list_rate_in[k];
                  list_idx_ff[k]  <= list_idx_in[k];
               end
            end
         end
         hcqd_pkg::ST_MARK: begin
            if (mark_go) begin
               mark_ff <= mark_ff + 1'b1;
            end
         end
         hcqd_pkg::ST_DONE: begin
            acc_ff     <= 1'b1;
            o_hit_ff   <= hit_ff;
            o_miss_ff  <= miss_ff;
            o_rate_ff  <= rate_ff;
            o_rssi_ff  <= rssi_ff;
            den_ff     <= cfg.smart_enable && flags_ff[ich];
            o_total_ff <= total_ff;
            o_mask_ff  <= mask_now;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = acc_ff;
   assign rsp_hit_count      = o_hit_ff;
   assign rsp_miss_count     = o_miss_ff;
   assign rsp_miss_percent   = o_rate_ff;
   assign rsp_rssi_average   = o_rssi_ff;
   assign rsp_channel_denied = den_ff;
   assign rsp_denied_total   = o_total_ff;
   assign rsp_denied_mask    = o_mask_ff;

endmodule

@@ sv/hop_channel_quality_denylist.sv @@
// Channel quality tracker with adaptive-hopping denylist. One transaction per hop
// carries a channel, a received/missed flag and the RSSI; each returns one
// result with the channel's updated hit/miss counters, miss percentage, smoothed
// RSSI and the denylist, which an in-range channel rebuilds. An out-of-range
// channel is answered without touching the statistics; an in-range one updates
// its entry, divides for its own miss percentage when it has enough samples and,
// when the denylist is built (smart_enable set and 8 or more channels), sweeps
// the channels, reading one statistics memory entry per step: it skips the sync
// channel and those with too few samples, divides for the rest and inserts each
// eligible rate into a sorted list, then marks the denylisted channels. The
// single bit-serial divider is shared by the channel's own miss percentage and
// the rebuild sweep across all channels. A two-entry queue sits between input and
// back end, so new transactions are taken while a rebuild runs or a result
// waits. Writing channel_count or sync_channel clears all statistics at once
// (valid bits, no clearing pass); configuration must be written while the block
// is idle.
module hop_channel_quality_denylist #(
   parameter int CHANNELS_MAX = 32
) (
   input  logic              clock,
   input  logic              reset,
   // input channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [5:0]        req_channel,
   input  logic              req_received_ok,
   input  logic signed [7:0] req_signal_strength,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_accepted,
   output logic [7:0]        rsp_hit_count,
   output logic [7:0]        rsp_miss_count,
   output logic [7:0]        rsp_miss_percent,
   output logic signed [7:0] rsp_rssi_average,
   output logic              rsp_channel_denied,
   output logic [4:0]        rsp_denied_total,
   output logic [31:0]       rsp_denied_mask,
   // configuration write port
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_wr_index,
   input  logic [8:0]        csr_wr_data
);

   localparam int CW = hcqd_pkg::COUNT_W;

   // configuration registers
   logic       smart_ff;
   logic [5:0] count_ff;
   logic [4:0] sync_ff;
   logic [8:0] min_ff;
   logic [6:0] score_ff;

   logic [CW-1:0]             eff_count;
   hcqd_pkg::cfg_type         cfg;
   hcqd_pkg::queue_head_type  head;
   logic                      pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         smart_ff <= 1'b0;
         count_ff <= 6'd0;
         sync_ff  <= 5'd0;
         min_ff   <= 9'd16;
         score_ff <= 7'd50;
      end else if (csr_wr_en) begin
         case (csr_wr_index)
            hcqd_pkg::REG_SMART: smart_ff <= csr_wr_data[0];
            hcqd_pkg::REG_COUNT: count_ff <= csr_wr_data[5:0];
            hcqd_pkg::REG_SYNC:  sync_ff  <= csr_wr_data[4:0];
            hcqd_pkg::REG_MIN:   min_ff   <= csr_wr_data;
            hcqd_pkg::REG_SCORE: score_ff <= csr_wr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   // counts above CHANNELS_MAX act as CHANNELS_MAX; a sync channel out of
   // range falls back to channel 0
   assign eff_count = ({1'b0, count_ff} > CW'(CHANNELS_MAX)) ? CW'(CHANNELS_MAX)
                                                            : {1'b0, count_ff};

   always_comb begin
      cfg.smart_enable = smart_ff;
      cfg.count        = eff_count;
      cfg.sync         = ({2'b00, sync_ff} < eff_count) ? {1'b0, sync_ff} : 6'd0;
      cfg.min_samples  = min_ff;
      cfg.deny_score   = score_ff;
      // statistics clear on the same edge as the write
      cfg.clear        = csr_wr_en && ((csr_wr_index == hcqd_pkg::REG_COUNT) ||
                                       (csr_wr_index == hcqd_pkg::REG_SYNC));
   end

   hcqd_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_channel         (req_channel),
      .req_received_ok     (req_received_ok),
      .req_signal_strength (req_signal_strength),
      .cfg                 (cfg),
      .head                (head),
      .pop                 (pop)
   );

   hcqd_back #(
      .CHANNELS_MAX (CHANNELS_MAX)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accepted       (rsp_accepted),
      .rsp_hit_count      (rsp_hit_count),
      .rsp_miss_count     (rsp_miss_count),
      .rsp_miss_percent   (rsp_miss_percent),
      .rsp_rssi_average   (rsp_rssi_average),
      .rsp_channel_denied (rsp_channel_denied),
      .rsp_denied_total   (rsp_denied_total),
      .rsp_denied_mask    (rsp_denied_mask)
   );

endmodule

@@ sv/hcqd_checker.sv @@
`include "hop_channel_quality_denylist_assert.svh"

module hcqd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_accepted,
   input logic [7:0]        rsp_hit_count,
   input logic [7:0]        rsp_miss_count,
   input logic [7:0]        rsp_miss_percent,
   input logic signed [7:0] rsp_rssi_average,
   input logic              rsp_channel_denied
);

   `HCQD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // ignored record reports empty statistics
   `HCQD_ASSERT_NOW(a_ignored_empty, clock, reset, rsp_valid && !rsp_accepted, rsp_hit_count == 8'd0 && rsp_miss_count == 8'd0 && rsp_miss_percent == 8'd255 && rsp_rssi_average == 8'sd0 && !rsp_channel_denied)

   // a recorded channel has just counted at least one sample
   `HCQD_ASSERT_NOW(a_counted, clock, reset, rsp_valid && rsp_accepted, rsp_hit_count != 8'd0 || rsp_miss_count != 8'd0)

   `HCQD_ASSERT_NOW(a_pct_range, clock, reset, rsp_valid && rsp_miss_percent != 8'd255, rsp_miss_percent <= 8'd100)

endmodule

bind hop_channel_quality_denylist hcqd_checker u_hcqd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_accepted       (rsp_accepted),
   .rsp_hit_count      (rsp_hit_count),
   .rsp_miss_count     (rsp_miss_count),
   .rsp_miss_percent   (rsp_miss_percent),
   .rsp_rssi_average   (rsp_rssi_average),
   .rsp_channel_denied (rsp_channel_denied)
);

@@ sim/hop_channel_quality_denylist_checker.sv @@
module hop_channel_quality_denylist_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [5:0]        req_channel,
   input  logic              req_received_ok,
   input  logic signed [7:0] req_signal_strength,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_accepted,
   input  logic [7:0]        rsp_hit_count,
   input  logic [7:0]        rsp_miss_count,
   input  logic [7:0]        rsp_miss_percent,
   input  logic signed [7:0] rsp_rssi_average,
   input  logic              rsp_channel_denied,
   input  logic [4:0]        rsp_denied_total,
   input  logic [31:0]       rsp_denied_mask,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_wr_index,
   input  logic [8:0]        csr_wr_data,
   output int                fail_count,
   output int                pending
);

   typedef struct {
      logic              accepted;
      logic [7:0]        hit_count;
      logic [7:0]        miss_count;
      logic [7:0]        miss_percent;
      logic signed [7:0] rssi_average;
      logic              channel_denied;
      logic [4:0]        denied_total;
      logic [31:0]       denied_mask;
   } hop_outcome_type;

   hop_outcome_type outcome_q[$];

   logic [7:0]        hits[32];
   logic [7:0]        misses[32];
   logic signed [7:0] rssi_avg[32];
   logic              rssi_seen[32];
   logic              denied[32];
   logic [4:0]        denied_sum;

   logic       cfg_smart;
   logic [5:0] cfg_count;
   logic [4:0] cfg_sync;
   logic [8:0] cfg_min;
   logic [6:0] cfg_score;

   assign pending = outcome_q.size();

   function automatic int active_channels();
      return (cfg_count > 32) ? 32 : int'(cfg_count);
   endfunction

   function automatic logic [7:0] miss_rate(int c);
      int samples;
      samples = int'(hits[c]) + int'(misses[c]);
      if (samples < int'(cfg_min) || samples == 0) return hcqd_pkg::RATE_NONE;
      return 8'((int'(misses[c]) * 100) / samples);
   endfunction

   task automatic clear_stats();
      for (int c = 0; c < 32; c++) begin
         hits[c] = 0; misses[c] = 0; rssi_avg[c] = 0; rssi_seen[c] = 0; denied[c] = 0;
      end
      denied_sum = 0;
   endtask

   task automatic pick_denied_set();
      int n, sync_ch, best, best_rate, r;
      n = active_channels();
      sync_ch = (int'(cfg_sync) < n) ? int'(cfg_sync) : 0;
      for (int c = 0; c < 32; c++) denied[c] = 0;
      denied_sum = 0;
      if (!cfg_smart || n < 8) return;
      for (int round = 0; round < n / 4; round++) begin
         best = -1;
         best_rate = 0;
         for (int c = 0; c < n; c++) begin
            if (c == sync_ch || denied[c]) continue;
            r = int'(miss_rate(c));
            if (r == 255 || r < int'(cfg_score)) continue;
            if (r > best_rate) begin
               best_rate = r;
               best = c;
            end
         end
         if (best < 0) break;
         denied[best] = 1;
         denied_sum++;
      end
   endtask

   task automatic record_hop(int ch, logic ok, logic signed [7:0] rssi);
      hop_outcome_type o;
      o = '{accepted: 0, hit_count: 0, miss_count: 0, miss_percent: hcqd_pkg::RATE_NONE,
            rssi_average: 0, channel_denied: 0, denied_total: 0, denied_mask: 0};
      if (ch < active_channels()) begin
         if (hits[ch] == hcqd_pkg::CNT_SAT || misses[ch] == hcqd_pkg::CNT_SAT) begin
            hits[ch] = hits[ch] >> 1;
            misses[ch] = misses[ch] >> 1;
         end
         if (ok) begin
            hits[ch]++;
            if (!rssi_seen[ch]) begin
               rssi_avg[ch] = rssi;
               rssi_seen[ch] = 1;
            end else begin
               rssi_avg[ch] = 8'((int'(rssi_avg[ch]) * 7 + int'(rssi)) / 8);
            end
         end else begin
            misses[ch]++;
         end
         pick_denied_set();
         o.accepted = 1;
         o.hit_count = hits[ch];
         o.miss_count = misses[ch];
         o.miss_percent = miss_rate(ch);
         o.rssi_average = rssi_avg[ch];
         o.channel_denied = cfg_smart && denied[ch];
      end
      for (int c = 0; c < 32; c++) o.denied_mask[c] = denied[c];
      o.denied_total = denied_sum;
      outcome_q.push_back(o);
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      hop_outcome_type o;
      if (reset) begin
         cfg_smart = 0; cfg_count = 0; cfg_sync = 0; cfg_min = 16; cfg_score = 50;
         clear_stats();
         outcome_q.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (hcqd_pkg::reg_index_type'(csr_wr_index))
               hcqd_pkg::REG_SMART: cfg_smart = csr_wr_data[0];
               hcqd_pkg::REG_COUNT: begin cfg_count = csr_wr_data[5:0]; clear_stats(); end
               hcqd_pkg::REG_SYNC:  begin cfg_sync = csr_wr_data[4:0]; clear_stats(); end
               hcqd_pkg::REG_MIN:   cfg_min = csr_wr_data;
               hcqd_pkg::REG_SCORE: cfg_score = csr_wr_data[6:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            record_hop(int'(req_channel), req_received_ok, req_signal_strength);
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $error("result transaction with no expectation pending");
               fail_count++;
            end else begin
               o = outcome_q.pop_front();
               check_field("accepted", o.accepted, rsp_accepted);
               check_field("hit_count", o.hit_count, rsp_hit_count);
               check_field("miss_count", o.miss_count, rsp_miss_count);
               check_field("miss_percent", o.miss_percent, rsp_miss_percent);
               check_field("rssi_average", 8'(o.rssi_average), 8'(rsp_rssi_average));
               check_field("channel_denied", o.channel_denied, rsp_channel_denied);
               check_field("denied_total", o.denied_total, rsp_denied_total);
               check_field("denied_mask", o.denied_mask, rsp_denied_mask);
            end
         end
      end
   end

endmodule

@@ sim/hop_channel_quality_denylist_test.sv @@
module hop_channel_quality_denylist_test;

   // Watchdog: cycles with no transaction on any port; the limit is set well
   // above a rebuild and the long receiver hold-off, so this is generous.
   localparam int IDLE_LIMIT = 20000;
   localparam int LONG_HOLD  = 3000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic [5:0]        req_channel = 0;
   logic              req_received_ok = 0;
   logic signed [7:0] req_signal_strength = 0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic              rsp_accepted;
   logic [7:0]        rsp_hit_count;
   logic [7:0]        rsp_miss_count;
   logic [7:0]        rsp_miss_percent;
   logic signed [7:0] rsp_rssi_average;
   logic              rsp_channel_denied;
   logic [4:0]        rsp_denied_total;
   logic [31:0]       rsp_denied_mask;
   logic              csr_wr_en = 0;
   logic [2:0]        csr_wr_index = 0;
   logic [8:0]        csr_wr_data = 0;

   int fail_count;
   int pending;

   // idle percentages, changed per phase by the stimulus process
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   // set once by the stimulus; the receiver process counts the hold-off itself
   logic long_hold_go = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   hop_channel_quality_denylist dut (.*);

   hop_channel_quality_denylist_checker checker_i (.*);

   // Receiver: random stalls, plus one long hold-off to back the block up.
   int  hold_left;
   logic hold_done;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         hold_left <= 0;
         hold_done <= 0;
      end else if (long_hold_go && !hold_done) begin
         hold_done <= 1;
         hold_left <= LONG_HOLD;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // One hop transaction. Valid is lowered only during a gap or by drain, so
   // back-to-back transactions keep it high with a single assignment per edge.
   task automatic send_hop(logic [5:0] ch, logic ok, logic signed [7:0] rssi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_channel <= ch;
      req_received_ok <= ok;
      req_signal_strength <= rssi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      if (req_valid) begin
         req_valid <= 0;
      end
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(hcqd_pkg::reg_index_type idx, logic [8:0] value);
      csr_wr_en <= 1;
      csr_wr_index <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   task automatic set_mode(int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
         default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
   endtask

   // Random hops: mostly in-range channels, every third channel lossy so that
   // the denylist actually fills; a tenth of the traffic is any channel.
   task automatic random_hops(int n, int active);
      logic [5:0] ch;
      logic ok;
      for (int i = 0; i < n; i++) begin
         if (active > 0 && $urandom_range(9) != 0)
            ch = 6'($urandom_range(active - 1));
         else
            ch = 6'($urandom_range(63));
         if (ch % 3 == 0) ok = ($urandom_range(99) < 20);
         else ok = ($urandom_range(99) < 85);
         send_hop(ch, ok, 8'($urandom));
      end
   endtask

   task automatic configure(logic smart, logic [5:0] cnt, logic [4:0] sync_ch,
                            logic [8:0] min_s, logic [6:0] score);
      write_reg(hcqd_pkg::REG_SMART, 9'(smart));
      write_reg(hcqd_pkg::REG_COUNT, 9'(cnt));
      write_reg(hcqd_pkg::REG_SYNC, 9'(sync_ch));
      write_reg(hcqd_pkg::REG_MIN, min_s);
      write_reg(hcqd_pkg::REG_SCORE, 9'(score));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: defaults (count 0) ignore everything, then 32 channels.
      send_hop(6'd5, 1, 8'sd10);
      drain();
      configure(1, 6'd32, 5'd3, 9'd4, 7'd50);
      send_hop(6'd63, 0, -8'sd1);          // out of range
      send_hop(6'd32, 1, 8'sd0);           // just past the last channel
      send_hop(6'd0, 1, -8'sd128);         // first RSSI stored as is
      send_hop(6'd0, 1, 8'sd127);          // averaging from the extremes
      send_hop(6'd0, 1, -8'sd3);           // negative average truncates toward zero
      send_hop(6'd31, 1, 8'sd127);
      for (int i = 0; i < 5; i++) send_hop(6'd3, 0, 8'sd0);  // sync never denied
      for (int i = 0; i < 5; i++) send_hop(6'd7, 0, 8'sd0);  // tie with channel 9
      for (int i = 0; i < 5; i++) send_hop(6'd9, 0, 8'sd0);
      send_hop(6'd1, 0, 8'sd0);             // too few samples
      send_hop(6'd2, 1, 8'sd50);
      drain();

      set_mode(0);
      random_hops(60, 32);
      drain();

      // Eight channels, zero score: only a rate above zero counts. Long
      // receiver hold-off first, then a counter driven into saturation.
      configure(1, 6'd8, 5'd7, 9'd0, 7'd0);
      set_mode(1);
      long_hold_go = 1;
      for (int i = 0; i < 40; i++) send_hop(6'($urandom_range(7)), 1, 8'($urandom));
      for (int i = 0; i < 270; i++)
         send_hop(6'd2, ($urandom_range(99) < 5), 8'($urandom));
      set_mode(2);
      random_hops(80, 8);
      drain();

      // Enable off, sync beyond count, unreachable sample floor, top score.
      configure(0, 6'd20, 5'd31, 9'd510, 7'd100);
      set_mode(3);
      random_hops(50, 20);
      drain();

      // Count above the maximum, score 100 with a low floor.
      configure(1, 6'd63, 5'd0, 9'd16, 7'd100);
      set_mode(0);
      for (int i = 0; i < 20; i++) send_hop(6'd4, 0, 8'($urandom));
      random_hops(60, 32);
      drain();

      // Fewer than eight channels: never any denylist.
      configure(1, 6'd7, 5'd2, 9'd1, 7'd30);
      set_mode(1);
      random_hops(50, 7);
      drain();

      // Unused register index, then zero channels.
      write_reg(hcqd_pkg::reg_index_type'(3'd7), 9'h1FF);
      configure(1, 6'd0, 5'd0, 9'd1, 7'd1);
      set_mode(3);
      random_hops(20, 0);
      drain();

      repeat (400) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
